>>> rtl/core/urt_pkg.sv
// shared types and constants for the udp peer reflector table
// used by urt_front, urt_engine and udp_peer_reflector_table; no dependencies
package urt_pkg;

  localparam int PEER_SLOTS_DEFAULT = 16;
  localparam logic [7:0] GRACE_RESET = 8'd16;

  typedef enum logic [1:0] {
    CLS_STUN    = 2'd0,
    CLS_DTLS    = 2'd1,
    CLS_SRTP    = 2'd2,
    CLS_UNKNOWN = 2'd3
  } urt_class_t;

  // classified item handed from the front to the engine
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    urt_class_t  cls;
    logic [31:0] sid;
  } urt_item_t;

  // one table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] session;
    logic [7:0]  grace;
  } urt_rec_t;

  typedef struct packed {
    urt_class_t  cls;
    logic [3:0]  src_slot;
    logic        has_dest;
    logic        dropped;
    logic [3:0]  dest_slot;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        last;
  } urt_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_GRACE,
    ST_FAN,
    ST_FAN_RD,
    ST_EMIT
  } urt_state_t;

endpackage

>>> rtl/core/udp_peer_reflector_table.sv
// Peer table for a UDP reflector. Each item pushed is one datagram header; it is
// classified (STUN, DTLS, SRTP, unknown), looked up in a PEER_SLOTS-entry peer
// table by address and port or by session id, inserted on a miss (becoming
// master with a grace count of grace_packets), then dropped, answered with one
// result without a destination if no other peer is valid, or fanned out as one
// result per other valid peer in ascending slot order, last set on the final one.
// A two-item queue sits in front of the table engine, which works on one item
// at a time, paced by the single read port of the table memory, scanned once
// for the lookup and once for the fan-out. A result waits in an output register
// while the engine moves on. The user must write grace_packets through cfg_write
// and cfg_data only while the block is idle; the block does not enforce this.
// depends on urt_pkg, urt_front, urt_engine
module udp_peer_reflector_table import urt_pkg::*; #(
  parameter int PEER_SLOTS = PEER_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] source_ip,
  input  logic [15:0] source_port,
  input  logic [15:0] packet_length,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [31:0] id_word,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  packet_class,
  output logic [3:0]  source_slot,
  output logic        has_dest,
  output logic        dropped,
  output logic [3:0]  dest_slot,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port,
  output logic        last
);

  logic [7:0]  grace_packets;
  logic        item_valid;
  logic        item_take;
  urt_item_t   item;
  logic        res_valid;
  urt_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_packets <= GRACE_RESET;
    end else if (cfg_write) begin
      grace_packets <= cfg_data;
    end
  end

  urt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .source_ip     (source_ip),
    .source_port   (source_port),
    .packet_length (packet_length),
    .first_byte    (first_byte),
    .second_byte   (second_byte),
    .third_byte    (third_byte),
    .id_word       (id_word),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item)
  );

  urt_engine #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .grace_packets (grace_packets),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item),
    .res_valid     (res_valid),
    .res_take      (pop),
    .res           (res)
  );

  assign empty        = !res_valid;
  assign packet_class = res.cls;
  assign source_slot  = res.src_slot;
  assign has_dest     = res.has_dest;
  assign dropped      = res.dropped;
  assign dest_slot    = res.dest_slot;
  assign dest_ip      = res.dest_ip;
  assign dest_port    = res.dest_port;
  assign last         = res.last;

endmodule

>>> rtl/core/urt_front.sv
// front end: accepts datagram headers, classifies them and queues them
// depends on urt_pkg
module urt_front import urt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] source_ip,
  input  logic [15:0] source_port,
  input  logic [15:0] packet_length,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [31:0] id_word,
  output logic        item_valid,
  input  logic        item_take,
  output urt_item_t   item
);

  localparam logic [7:0]  STUN_B0_A   = 8'h00;
  localparam logic [7:0]  STUN_B0_B   = 8'h01;
  localparam logic [7:0]  STUN_B1_A   = 8'h01;
  localparam logic [7:0]  STUN_B1_B   = 8'h11;
  localparam logic [7:0]  STUN_B2     = 8'h00;
  localparam logic [7:0]  ALT_B0      = 8'd90;
  localparam logic [7:0]  ALT_B1      = 8'h6d;
  localparam logic [7:0]  DTLS_B0_A   = 8'h14;
  localparam logic [7:0]  DTLS_B0_B   = 8'h16;
  localparam logic [7:0]  DTLS_B1     = 8'hfe;
  localparam logic [7:0]  DTLS_B2     = 8'hfd;
  localparam logic [7:0]  SRTP_B0_A   = 8'h80;
  localparam logic [7:0]  SRTP_B0_B   = 8'h90;
  localparam logic [7:0]  SRTP_B0_C   = 8'h81;
  localparam logic [15:0] ID_MIN_LEN  = 16'd36;

  urt_class_t cls;
  urt_item_t  in_item;
  logic       len_ge2;
  logic       len_ge3;

  urt_item_t  q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign len_ge2 = packet_length >= 16'd2;
  assign len_ge3 = packet_length >= 16'd3;

  always_comb begin
    if (len_ge3 && (first_byte == STUN_B0_A || first_byte == STUN_B0_B) &&
        (second_byte == STUN_B1_A || second_byte == STUN_B1_B) && third_byte == STUN_B2) begin
      cls = CLS_STUN;
    end else if (len_ge2 && first_byte == ALT_B0 && second_byte == ALT_B1) begin
      cls = CLS_STUN;
    end else if (len_ge3 && (first_byte == DTLS_B0_A || first_byte == DTLS_B0_B) &&
                 second_byte == DTLS_B1 && third_byte == DTLS_B2) begin
      cls = CLS_DTLS;
    end else if (len_ge2 && (first_byte == SRTP_B0_A || first_byte == SRTP_B0_B ||
                             first_byte == SRTP_B0_C)) begin
      cls = CLS_SRTP;
    end else begin
      cls = CLS_UNKNOWN;
    end
  end

  always_comb begin
    in_item.ip   = source_ip;
    in_item.port = source_port;
    in_item.cls  = cls;
    in_item.sid  = (cls == CLS_STUN && packet_length >= ID_MIN_LEN) ? id_word : 32'd0;
  end

  // two-entry queue toward the engine
  assign full       = count == 2'd2;
  assign item_valid = count != 2'd0;
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_item;
    end
  end

endmodule

>>> rtl/core/urt_engine.sv
// back end: peer table lookup, insert, drop decision and fan-out sequencer
// depends on urt_pkg; holds the peer table memory and the result register
module urt_engine import urt_pkg::*; #(
  parameter int PEER_SLOTS = PEER_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  grace_packets,
  input  logic        item_valid,
  output logic        item_take,
  input  urt_item_t   item,
  output logic        res_valid,
  input  logic        res_take,
  output urt_result_t res
);

  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(PEER_SLOTS + 1);
  localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(PEER_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PEER_SLOTS - 1);

  urt_state_t state;
  urt_state_t state_next;

  urt_rec_t mem [PEER_SLOTS];
  urt_rec_t rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  urt_rec_t          wr_rec;

  urt_item_t           job;
  logic [CNT_W-1:0]    idx;
  logic [SLOT_W-1:0]   idx_s;
  logic                cmp_vld;
  logic [SLOT_W-1:0]   cmp_idx;
  logic                found;
  logic [SLOT_W-1:0]   src;
  logic [7:0]          grace_reg;
  logic                emit_drop;
  logic [PEER_SLOTS-1:0] slot_valid;
  logic [SLOT_W-1:0]   next_free;
  logic [SLOT_W-1:0]   master;

  logic                issue;
  logic                hit;
  logic [7:0]          cur_grace;
  logic                drop;
  logic [PEER_SLOTS-1:0] src_oh;
  logic [PEER_SLOTS-1:0] above;
  logic                others;
  logic                more_after;
  logic                cand;
  logic                out_free;
  logic                load_dest;
  logic                load_plain;

  assign idx_s     = idx[SLOT_W-1:0];
  assign issue     = idx != CNT_END;
  assign hit       = slot_valid[cmp_idx] &&
                     ((rd_data.addr == job.ip && rd_data.port == job.port) ||
                      rd_data.session == job.sid);
  assign cur_grace = found ? rd_data.grace : grace_reg;
  assign drop      = job.cls != CLS_STUN && src != master && cur_grace == 8'd0;
  assign out_free  = !res_valid || res_take;
  assign cand      = issue && slot_valid[idx_s] && idx_s != src;

  always_comb begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      src_oh[i] = SLOT_W'(i) == src;
      above[i]  = SLOT_W'(i) > idx_s;
    end
  end

  assign others     = |(slot_valid & ~src_oh);
  assign more_after = |(slot_valid & ~src_oh & above);

  always_comb begin
    case (state)
      ST_RESOLVE: rd_addr = src;
      default:    rd_addr = idx_s;
    endcase
  end

  always_comb begin
    state_next = state;
    item_take  = 1'b0;
    wr_en      = 1'b0;
    load_dest  = 1'b0;
    load_plain = 1'b0;
    wr_rec.addr    = found ? rd_data.addr : job.ip;
    wr_rec.port    = found ? rd_data.port : job.port;
    wr_rec.session = found ? rd_data.session : job.sid;
    wr_rec.grace   = (cur_grace == 8'd0) ? 8'd0 : cur_grace - 8'd1;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_take  = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (!issue && !cmp_vld) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_next = ST_GRACE;
      end
      ST_GRACE: begin
        if (drop) begin
          state_next = ST_EMIT;
        end else begin
          wr_en = !found || cur_grace != 8'd0;
          state_next = others ? ST_FAN : ST_EMIT;
        end
      end
      ST_FAN: begin
        if (!issue) begin
          state_next = ST_IDLE;
        end else if (cand) begin
          state_next = ST_FAN_RD;
        end
      end
      ST_FAN_RD: begin
        if (out_free) begin
          load_dest  = 1'b1;
          state_next = more_after ? ST_FAN : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_plain = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // peer table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[src] <= wr_rec;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_free  <= '0;
      master     <= '0;
      res_valid  <= 1'b0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            job     <= item;
            idx     <= '0;
            found   <= 1'b0;
            cmp_vld <= 1'b0;
          end
        end
        ST_MATCH: begin
          cmp_vld <= issue;
          cmp_idx <= idx_s;
          if (issue) begin
            idx <= idx + CNT_W'(1);
          end
          // lowest matching slot wins
          if (cmp_vld && hit && !found) begin
            found <= 1'b1;
            src   <= cmp_idx;
          end
        end
        ST_RESOLVE: begin
          if (!found) begin
            src                   <= next_free;
            slot_valid[next_free] <= 1'b1;
            master                <= next_free;
            next_free             <= (next_free == SLOT_LAST) ? '0 : next_free + SLOT_W'(1);
            grace_reg             <= grace_packets;
          end
        end
        ST_GRACE: begin
          emit_drop <= drop;
          idx       <= '0;
        end
        ST_FAN: begin
          if (issue && !cand) begin
            idx <= idx + CNT_W'(1);
          end
        end
        ST_FAN_RD: begin
          if (out_free) begin
            idx <= idx + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase

      if (load_dest || load_plain) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_dest) begin
      res.cls       <= job.cls;
      res.src_slot  <= 4'(src);
      res.has_dest  <= 1'b1;
      res.dropped   <= 1'b0;
      res.dest_slot <= 4'(idx_s);
      res.dest_ip   <= rd_data.addr;
      res.dest_port <= rd_data.port;
      res.last      <= !more_after;
    end else if (load_plain) begin
      res.cls       <= job.cls;
      res.src_slot  <= 4'(src);
      res.has_dest  <= 1'b0;
      res.dropped   <= emit_drop;
      res.dest_slot <= 4'd0;
      res.dest_ip   <= 32'd0;
      res.dest_port <= 16'd0;
      res.last      <= 1'b1;
    end
  end

endmodule
